// ----- sv/spq_pkg.sv -----
// Shared types and codes for the sorted priority queue.
// Holds operation and result codes, controller states and the control structs.
package spq_pkg;

    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_CONTAINS = 2'd1;
    localparam logic [1:0] OP_REMOVE   = 2'd2;

    localparam logic [1:0] RES_DONE  = 2'd0;
    localparam logic [1:0] RES_EMPTY = 2'd1;
    localparam logic [1:0] RES_FULL  = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_TEST  = 5'b00100,
        S_PUT   = 5'b01000,
        S_REPLY = 5'b10000
    } state_t;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic shift;
        logic put;
        logic step;
        logic hit;
        logic pop;
        logic reply;
    } spq_cmd_t;

    typedef struct packed {
        logic in_insert;
        logic in_contains;
        logic in_remove;
        logic is_insert;
        logic is_contains;
        logic is_remove;
        logic empty;
        logic full;
        logic greater;
        logic equal;
        logic pos_one;
        logic pos_last;
        logic out_free;
    } spq_stat_t;

endpackage

// ----- sv/spq_ctrl.sv -----
// Controller state machine for the sorted priority queue.
// Depends on spq_pkg; drives commands to spq_datapath from its status.
module spq_ctrl
    import spq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  spq_stat_t stat,
    output spq_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (stat.in_insert) begin
                        if (stat.full) begin
                            state_next = S_REPLY;
                        end else if (stat.empty) begin
                            state_next = S_PUT;
                        end else begin
                            state_next = S_READ;
                        end
                    end else if (stat.in_contains || stat.in_remove) begin
                        state_next = stat.empty ? S_REPLY : S_READ;
                    end else begin
                        state_next = S_REPLY;
                    end
                end
            end
            S_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = S_TEST;
            end
            S_TEST: begin
                if (stat.is_insert) begin
                    if (stat.greater) begin
                        cmd.shift  = 1'b1;
                        state_next = stat.pos_one ? S_PUT : S_READ;
                    end else begin
                        state_next = S_PUT;
                    end
                end else if (stat.is_contains) begin
                    if (stat.equal) begin
                        cmd.hit    = 1'b1;
                        state_next = S_REPLY;
                    end else begin
                        cmd.step   = 1'b1;
                        state_next = stat.pos_last ? S_REPLY : S_READ;
                    end
                end else if (stat.is_remove) begin
                    cmd.pop    = 1'b1;
                    state_next = S_REPLY;
                end else begin
                    state_next = S_REPLY;
                end
            end
            S_PUT: begin
                cmd.put    = 1'b1;
                state_next = S_REPLY;
            end
            S_REPLY: begin
                if (stat.out_free) begin
                    cmd.reply  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_reply_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.reply |-> stat.out_free)
        else $error("result loaded while output register occupied");
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transaction taken while busy");
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("controller state not one-hot");
`endif

endmodule

// ----- sv/spq_datapath.sv -----
// Datapath for the sorted priority queue: tag memory ring, scan pointer, result register.
// Depends on spq_pkg; obeys commands from spq_ctrl and reports status to it.
module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH    = 64,
    parameter int TAG_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [1:0]                   s_operation,
    input  logic [15:0]                  s_item_tag,
    input  spq_cmd_t                     cmd,
    output spq_stat_t                    stat,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_status,
    output logic                         m_found,
    output logic [15:0]                  m_out_tag,
    output logic [$clog2(DEPTH+1)-1:0]   m_fill_count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;

    logic [TAG_BITS-1:0] mem [DEPTH];
    logic [TAG_BITS-1:0] rd_data_reg;

    logic [CNT_W-1:0]    count_reg;
    logic [IDX_W-1:0]    head_reg;
    logic [CNT_W-1:0]    pos_reg;
    logic [1:0]          op_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic [1:0]          status_reg;
    logic                found_reg;
    logic [15:0]         out_tag_reg;

    logic                m_valid_reg;
    logic [1:0]          m_status_reg;
    logic                m_found_reg;
    logic [15:0]         m_out_tag_reg;
    logic [CNT_W-1:0]    m_fill_count_reg;

    logic [TAG_BITS+15:0] in_ext;
    logic [TAG_BITS+15:0] head_ext;
    logic [TAG_BITS-1:0]  in_tag;
    logic [15:0]          popped_tag;
    logic [CNT_W-1:0]     rd_idx;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     wr_addr;
    logic [TAG_BITS-1:0]  wr_data;
    logic                 wr_en;
    logic [1:0]           status_next;
    logic [IDX_W-1:0]     head_next;

    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                             input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, base} + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign in_ext     = {{TAG_BITS{1'b0}}, s_item_tag};
    assign in_tag     = in_ext[TAG_BITS-1:0];
    assign head_ext   = {16'b0, rd_data_reg};
    assign popped_tag = head_ext[15:0];

    assign rd_idx  = (op_reg == OP_INSERT) ? (pos_reg - CNT_W'(1)) : pos_reg;
    assign rd_addr = phys(head_reg, rd_idx);
    assign wr_addr = phys(head_reg, pos_reg);
    assign wr_en   = cmd.shift | cmd.put;
    assign wr_data = cmd.shift ? rd_data_reg : tag_reg;

    assign head_next = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);

    always_comb begin
        status_next = RES_DONE;
        if ((s_operation == OP_INSERT) && (count_reg == CNT_W'(DEPTH))) begin
            status_next = RES_FULL;
        end else if ((s_operation == OP_REMOVE) && (count_reg == '0)) begin
            status_next = RES_EMPTY;
        end
    end

    assign stat.in_insert   = (s_operation == OP_INSERT);
    assign stat.in_contains = (s_operation == OP_CONTAINS);
    assign stat.in_remove   = (s_operation == OP_REMOVE);
    assign stat.is_insert   = (op_reg == OP_INSERT);
    assign stat.is_contains = (op_reg == OP_CONTAINS);
    assign stat.is_remove   = (op_reg == OP_REMOVE);
    assign stat.empty       = (count_reg == '0);
    assign stat.full        = (count_reg == CNT_W'(DEPTH));
    assign stat.greater     = (rd_data_reg > tag_reg);
    assign stat.equal       = (rd_data_reg == tag_reg);
    assign stat.pos_one     = (pos_reg == CNT_W'(1));
    assign stat.pos_last    = ((pos_reg + CNT_W'(1)) == count_reg);
    assign stat.out_free    = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            head_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.put) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (cmd.pop) begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.pop) begin
                head_reg <= head_next;
            end
            if (cmd.reply) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= s_operation;
            tag_reg     <= in_tag;
            pos_reg     <= (s_operation == OP_INSERT) ? count_reg : '0;
            status_reg  <= status_next;
            found_reg   <= 1'b0;
            out_tag_reg <= '0;
        end
        if (cmd.shift) begin
            pos_reg <= pos_reg - CNT_W'(1);
        end
        if (cmd.step) begin
            pos_reg <= pos_reg + CNT_W'(1);
        end
        if (cmd.hit) begin
            found_reg <= 1'b1;
        end
        if (cmd.pop) begin
            out_tag_reg <= popped_tag;
        end
        if (cmd.reply) begin
            m_status_reg     <= status_reg;
            m_found_reg      <= found_reg;
            m_out_tag_reg    <= out_tag_reg;
            m_fill_count_reg <= count_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_found      = m_found_reg;
    assign m_out_tag    = m_out_tag_reg;
    assign m_fill_count = m_fill_count_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");
    a_put_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.put |-> (count_reg != CNT_W'(DEPTH)))
        else $error("tag written into full queue");
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("remove did not drop fill count");
`endif

endmodule

// ----- sv/sorted_priority_queue.sv -----
// Sorted priority queue: one transaction at a time, tags kept ascending in a ring memory.
// Remove tests the head entry; insert moves each larger entry up from the tail, then puts;
// contains scans from the head to a match or the last entry. An empty insert puts directly;
// a full insert, an empty remove or contains and an unused code reply directly. An entry visit is
// a registered memory read, then a compare; a new transaction waits until the result is loaded.
// Reset: synchronous active low, empties the queue at once; tag memory is not cleared.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH    = 64,
    parameter int TAG_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_operation,
    input  logic [15:0]                  s_item_tag,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_status,
    output logic                         m_found,
    output logic [15:0]                  m_out_tag,
    output logic [$clog2(DEPTH+1)-1:0]   m_fill_count
);

    spq_cmd_t  cmd;
    spq_stat_t stat;

    spq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    spq_datapath #(
        .DEPTH    (DEPTH),
        .TAG_BITS (TAG_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_operation  (s_operation),
        .s_item_tag   (s_item_tag),
        .cmd          (cmd),
        .stat         (stat),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_found      (m_found),
        .m_out_tag    (m_out_tag),
        .m_fill_count (m_fill_count)
    );

endmodule

// ----- tb/sv/sorted_priority_queue_tb.sv -----
// Self-checking testbench for sorted_priority_queue: directed table, then phased random traffic.
// Depends on spq_pkg for operation and result codes; predicts each result itself unless a directed row fixes it.
module sorted_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int QUEUE_DEPTH = 64;
    localparam int FILL_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [1:0] OP_IDLE = 2'd3;
    localparam int TARGET_OPS = 950;
    localparam int DIRECTED_ROWS = 15;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef struct packed {
        logic [1:0]           status;
        logic                 found;
        logic [15:0]          out_tag;
        logic [FILL_BITS-1:0] fill_count;
    } queue_result_t;

    typedef struct packed {
        logic [1:0]    operation;
        logic [15:0]   tag;
        logic          fixed_result;
        queue_result_t result;
    } stimulus_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [1:0]           s_operation;
    logic [15:0]          s_item_tag;
    logic                 m_valid;
    logic                 m_ready;
    logic [1:0]           m_status;
    logic                 m_found;
    logic [15:0]          m_out_tag;
    logic [FILL_BITS-1:0] m_fill_count;

    logic [15:0]   stored_tags[$];
    queue_result_t pending_results[$];
    int            error_count = 0;
    bit            quiet_phase = 1'b0;
    bit            hold_off_due = 1'b0;

    stimulus_row_t directed_rows [DIRECTED_ROWS] = '{
        '{OP_REMOVE,   16'h0000, 1'b1, '{RES_EMPTY, 1'b0, 16'h0000, 7'd0}},
        '{OP_CONTAINS, 16'h0000, 1'b1, '{RES_DONE,  1'b0, 16'h0000, 7'd0}},
        '{OP_IDLE,     16'h5555, 1'b1, '{RES_DONE,  1'b0, 16'h0000, 7'd0}},
        '{OP_INSERT,   16'hFFFF, 1'b1, '{RES_DONE,  1'b0, 16'h0000, 7'd1}},
        '{OP_INSERT,   16'h0000, 1'b1, '{RES_DONE,  1'b0, 16'h0000, 7'd2}},
        '{OP_INSERT,   16'h8000, 1'b0, '0},
        '{OP_INSERT,   16'h8000, 1'b0, '0},
        '{OP_CONTAINS, 16'hFFFF, 1'b1, '{RES_DONE,  1'b1, 16'h0000, 7'd4}},
        '{OP_CONTAINS, 16'h7FFF, 1'b0, '0},
        '{OP_IDLE,     16'hAAAA, 1'b1, '{RES_DONE,  1'b0, 16'h0000, 7'd4}},
        '{OP_REMOVE,   16'h1234, 1'b1, '{RES_DONE,  1'b0, 16'h0000, 7'd3}},
        '{OP_REMOVE,   16'hFFFF, 1'b0, '0},
        '{OP_REMOVE,   16'h0000, 1'b0, '0},
        '{OP_REMOVE,   16'h8000, 1'b1, '{RES_DONE,  1'b0, 16'hFFFF, 7'd0}},
        '{OP_REMOVE,   16'hFFFF, 1'b1, '{RES_EMPTY, 1'b0, 16'h0000, 7'd0}}
    };

    sorted_priority_queue #(
        .DEPTH    (QUEUE_DEPTH),
        .TAG_BITS (16)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_item_tag   (s_item_tag),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_found      (m_found),
        .m_out_tag    (m_out_tag),
        .m_fill_count (m_fill_count)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic queue_result_t apply_queue_op(input logic [1:0] op,
                                                     input logic [15:0] tag);
        queue_result_t res;
        int pos;
        res = '0;
        case (op)
            OP_INSERT: begin
                if (stored_tags.size() >= QUEUE_DEPTH) begin
                    res.status = RES_FULL;
                end else begin
                    pos = stored_tags.size();
                    while (pos > 0 && stored_tags[pos-1] > tag) pos--;
                    stored_tags.insert(pos, tag);
                end
            end
            OP_CONTAINS: begin
                foreach (stored_tags[i]) begin
                    if (stored_tags[i] == tag) res.found = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (stored_tags.size() == 0) begin
                    res.status = RES_EMPTY;
                end else begin
                    res.out_tag = stored_tags[0];
                    stored_tags.delete(0);
                end
            end
            default: ;
        endcase
        res.fill_count = FILL_BITS'(stored_tags.size());
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [1:0] pick_op(input int kind);
        int r;
        r = $urandom_range(0, 99);
        case (kind)
            0: begin
                if (r < 85) return OP_INSERT;
                if (r < 93) return OP_CONTAINS;
                if (r < 97) return OP_REMOVE;
            end
            2: begin
                if (r < 85) return OP_REMOVE;
                if (r < 93) return OP_CONTAINS;
                if (r < 97) return OP_INSERT;
            end
            default: begin
                if (r < 35) return OP_INSERT;
                if (r < 65) return OP_CONTAINS;
                if (r < 95) return OP_REMOVE;
            end
        endcase
        return OP_IDLE;
    endfunction

    function automatic logic [15:0] pick_tag(input logic [1:0] op);
        int r;
        if (op == OP_CONTAINS && stored_tags.size() > 0 && $urandom_range(0, 1) == 1)
            return stored_tags[$urandom_range(0, stored_tags.size() - 1)];
        r = $urandom_range(0, 9);
        if (r < 4) return 16'($urandom_range(0, 15));
        if (r < 5) begin
            case ($urandom_range(0, 3))
                0: return 16'h0000;
                1: return 16'hFFFF;
                2: return 16'h8000;
                default: return 16'h7FFF;
            endcase
        end
        return 16'($urandom());
    endfunction

    task automatic offer(input logic [1:0] op, input logic [15:0] tag,
                         output queue_result_t predicted);
        s_valid     <= 1'b1;
        s_operation <= op;
        s_item_tag  <= tag;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = apply_queue_op(op, tag);
    endtask

    task automatic sender_gap();
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT) $display("%0t ns: %s", $realtime, msg);
    endtask

    initial begin
        queue_result_t predicted;
        int sent_ops;
        int phase;
        int phase_len;
        logic [1:0] op;
        logic [15:0] tag;
        s_valid     <= 1'b0;
        s_operation <= OP_INSERT;
        s_item_tag  <= '0;
        aresetn     <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        sent_ops = 0;
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            offer(directed_rows[r].operation, directed_rows[r].tag, predicted);
            pending_results.insert(pending_results.size(),
                                   directed_rows[r].fixed_result ?
                                   directed_rows[r].result : predicted);
            sent_ops++;
            sender_gap();
        end

        phase = 0;
        while (sent_ops < TARGET_OPS) begin
            quiet_phase = ($urandom_range(0, 4) == 0);
            if (phase == 1) hold_off_due = 1'b1;
            if (phase == 2 || $urandom_range(0, 5) == 0) begin
                s_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge aclk);
            end
            phase_len = (phase % 2 == 0) ? $urandom_range(90, 120) : $urandom_range(15, 40);
            for (int k = 0; k < phase_len && sent_ops < TARGET_OPS; k++) begin
                op  = pick_op(phase % 4);
                tag = pick_tag(op);
                offer(op, tag, predicted);
                pending_results.insert(pending_results.size(), predicted);
                sent_ops++;
                sender_gap();
            end
            phase++;
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("sorted_priority_queue_tb passed");
        end else begin
            $display("sorted_priority_queue_tb failed");
        end
        $finish;
    end

    initial begin
        int run_len;
        int stall;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            run_len = $urandom_range(1, 12);
            repeat (run_len) @(posedge aclk);
            if (hold_off_due) begin
                hold_off_due = 1'b0;
                stall = HOLD_OFF_CYCLES;
            end else begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        queue_result_t got;
        queue_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_status, m_found, m_out_tag, m_fill_count};
            if (pending_results.size() == 0) begin
                flag_error($sformatf("unexpected transaction: status %0d found %0d tag %0h fill %0d",
                                     got.status, got.found, got.out_tag, got.fill_count));
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (got.status !== want.status)
                    flag_error($sformatf("status: expected %0d, actual %0d",
                                         want.status, got.status));
                if (got.found !== want.found)
                    flag_error($sformatf("found: expected %0d, actual %0d",
                                         want.found, got.found));
                if (got.out_tag !== want.out_tag)
                    flag_error($sformatf("out_tag: expected %0h, actual %0h",
                                         want.out_tag, got.out_tag));
                if (got.fill_count !== want.fill_count)
                    flag_error($sformatf("fill_count: expected %0d, actual %0d",
                                         want.fill_count, got.fill_count));
            end
        end
    end

    initial begin
        #3_000_000;
        $display("sorted_priority_queue_tb failed");
        $finish;
    end

endmodule
